[sv/alu83_pkg.sv]
package alu83_pkg;

  // Operation codes carried in the input tuser field.
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_SUB = 4'd2,
    OP_SBC = 4'd3,
    OP_AND = 4'd4,
    OP_XOR = 4'd5,
    OP_OR  = 4'd6,
    OP_CP  = 4'd7,
    OP_INC = 4'd8,
    OP_DEC = 4'd9,
    OP_DAA = 4'd10,
    OP_CPL = 4'd11,
    OP_SCF = 4'd12,
    OP_CCF = 4'd13,
    OP_SRL = 4'd14,
    OP_RR  = 4'd15
  } op_t;

  // Field widths.
  localparam int unsigned DataW = 8;
  localparam int unsigned NibW  = 4;

  // Decimal adjust constants.
  localparam logic [DataW-1:0] BcdMax     = 8'h99;
  localparam logic [NibW-1:0]  NibbleMax  = 4'h9;
  localparam logic [NibW-1:0]  DaaAdjust  = 4'h6;

  // Per-stage load enables handed from the flow control to the datapath.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } adv_t;

endpackage

[sv/alu83_pipe.sv]
module alu83_pipe
  import alu83_pkg::*;
(
  input  logic             clk,
  input  adv_t             adv,
  input  op_t              op,
  input  logic [DataW-1:0] acc,
  input  logic [DataW-1:0] operand,
  input  logic             zero_in,
  input  logic             subtract_in,
  input  logic             half_in,
  input  logic             carry_in,
  output logic [DataW-1:0] result,
  output logic             zero_out,
  output logic             subtract_out,
  output logic             half_out,
  output logic             carry_out
);

  // Stage 1 registers: low nibble of the adder and decimal adjust decisions.
  op_t              s1_op;
  logic [DataW-1:0] s1_a;
  logic [DataW-1:0] s1_b;
  logic             s1_z;
  logic             s1_n;
  logic             s1_c;
  logic             s1_sub;
  logic [NibW-1:0]  s1_p_hi;
  logic [NibW-1:0]  s1_q_hi;
  logic [NibW:0]    s1_lo;
  logic             s1_cor_hi;
  logic             s1_cor_lo;
  logic             s1_daa_c;

  // Stage 2 registers: full sum, adjusted value and logic results.
  op_t              s2_op;
  logic [DataW-1:0] s2_a;
  logic             s2_z;
  logic             s2_n;
  logic             s2_c;
  logic             s2_sub;
  logic [DataW-1:0] s2_sum;
  logic             s2_half;
  logic             s2_carry;
  logic [DataW-1:0] s2_daa;
  logic             s2_daa_c;
  logic [DataW-1:0] s2_lres;
  logic             s2_b0;

  // Stage 1 combinational signals.
  logic             cin;
  logic             sub;
  logic             unary;
  logic [DataW-1:0] p;
  logic [DataW-1:0] q;
  logic [NibW:0]    lo;
  logic             cor_hi;
  logic             cor_lo;
  logic             daa_c;

  // Stage 2 combinational signals.
  logic [NibW:0]    hi;
  logic [DataW-1:0] adj;
  logic [DataW-1:0] daa_val;
  logic [DataW-1:0] lres;

  // Stage 3 combinational signals.
  logic [DataW-1:0] res_sel;
  logic             z_sel;
  logic             n_sel;
  logic             h_sel;
  logic             c_sel;
  logic             z_from_res;

  // Operand selection and low nibble add or subtract; its bit 4 is the half carry.
  always_comb begin
    cin   = ((op == OP_ADC) || (op == OP_SBC)) ? carry_in : 1'b0;
    sub   = (op == OP_SUB) || (op == OP_SBC) || (op == OP_CP) || (op == OP_DEC);
    unary = (op == OP_INC) || (op == OP_DEC);
    p     = unary ? operand : acc;
    q     = unary ? DataW'(1) : operand;
    if (sub) begin
      lo = {1'b0, p[NibW-1:0]} - {1'b0, q[NibW-1:0]} - {{NibW{1'b0}}, cin};
    end else begin
      lo = {1'b0, p[NibW-1:0]} + {1'b0, q[NibW-1:0]} + {{NibW{1'b0}}, cin};
    end
  end

  // Decimal adjust decisions from the incoming flags and accumulator.
  always_comb begin
    if (subtract_in) begin
      cor_hi = carry_in;
      cor_lo = half_in;
      daa_c  = carry_in;
    end else begin
      cor_hi = carry_in || (acc > BcdMax);
      cor_lo = half_in || (acc[NibW-1:0] > NibbleMax);
      daa_c  = cor_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      s1_op     <= op;
      s1_a      <= acc;
      s1_b      <= operand;
      s1_z      <= zero_in;
      s1_n      <= subtract_in;
      s1_c      <= carry_in;
      s1_sub    <= sub;
      s1_p_hi   <= p[DataW-1:NibW];
      s1_q_hi   <= q[DataW-1:NibW];
      s1_lo     <= lo;
      s1_cor_hi <= cor_hi;
      s1_cor_lo <= cor_lo;
      s1_daa_c  <= daa_c;
    end
  end

  // High nibble with the carry or borrow from the low nibble; bit 4 is the carry.
  always_comb begin
    if (s1_sub) begin
      hi = {1'b0, s1_p_hi} - {1'b0, s1_q_hi} - {{NibW{1'b0}}, s1_lo[NibW]};
    end else begin
      hi = {1'b0, s1_p_hi} + {1'b0, s1_q_hi} + {{NibW{1'b0}}, s1_lo[NibW]};
    end
  end

  // Decimal adjust: add or subtract the chosen correction.
  always_comb begin
    adj = {(s1_cor_hi ? DaaAdjust : {NibW{1'b0}}), (s1_cor_lo ? DaaAdjust : {NibW{1'b0}})};
    daa_val = s1_n ? (s1_a - adj) : (s1_a + adj);
  end

  // Bitwise and shift results.
  always_comb begin
    unique case (s1_op)
      OP_AND:  lres = s1_a & s1_b;
      OP_XOR:  lres = s1_a ^ s1_b;
      OP_OR:   lres = s1_a | s1_b;
      OP_CPL:  lres = ~s1_a;
      OP_SRL:  lres = {1'b0, s1_b[DataW-1:1]};
      OP_RR:   lres = {s1_c, s1_b[DataW-1:1]};
      default: lres = s1_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      s2_op    <= s1_op;
      s2_a     <= s1_a;
      s2_z     <= s1_z;
      s2_n     <= s1_n;
      s2_c     <= s1_c;
      s2_sub   <= s1_sub;
      s2_sum   <= {hi[NibW-1:0], s1_lo[NibW-1:0]};
      s2_half  <= s1_lo[NibW];
      s2_carry <= hi[NibW];
      s2_daa   <= daa_val;
      s2_daa_c <= s1_daa_c;
      s2_lres  <= lres;
      s2_b0    <= s1_b[0];
    end
  end

  // Final selection of result and flags.
  always_comb begin
    res_sel    = s2_a;
    z_sel      = s2_z;
    n_sel      = 1'b0;
    h_sel      = 1'b0;
    c_sel      = s2_c;
    z_from_res = 1'b1;
    unique case (s2_op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
        res_sel = s2_sum;
        n_sel   = s2_sub;
        h_sel   = s2_half;
        c_sel   = s2_carry;
      end
      OP_CP: begin
        z_sel      = (s2_sum == '0);
        z_from_res = 1'b0;
        n_sel      = 1'b1;
        h_sel      = s2_half;
        c_sel      = s2_carry;
      end
      OP_AND: begin
        res_sel = s2_lres;
        h_sel   = 1'b1;
        c_sel   = 1'b0;
      end
      OP_XOR, OP_OR: begin
        res_sel = s2_lres;
        c_sel   = 1'b0;
      end
      OP_INC, OP_DEC: begin
        res_sel = s2_sum;
        n_sel   = s2_sub;
        h_sel   = s2_half;
      end
      OP_DAA: begin
        res_sel = s2_daa;
        n_sel   = s2_n;
        c_sel   = s2_daa_c;
      end
      OP_CPL: begin
        res_sel    = s2_lres;
        z_from_res = 1'b0;
        n_sel      = 1'b1;
        h_sel      = 1'b1;
      end
      OP_SCF: begin
        z_from_res = 1'b0;
        c_sel      = 1'b1;
      end
      OP_CCF: begin
        z_from_res = 1'b0;
        c_sel      = ~s2_c;
      end
      OP_SRL, OP_RR: begin
        res_sel = s2_lres;
        c_sel   = s2_b0;
      end
      default: begin
        res_sel = s2_a;
      end
    endcase
    if (z_from_res) begin
      z_sel = (res_sel == '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      result       <= res_sel;
      zero_out     <= z_sel;
      subtract_out <= n_sel;
      half_out     <= h_sel;
      carry_out    <= c_sel;
    end
  end

endmodule

[sv/cpu_alu_8bit_flags_unit.sv]
// Channel  | Signals                          | Beat contents
// s_axis   | tvalid tready tdata[23:0] tuser  | operation, accumulator, operand, flags in
// m_axis   | tvalid tready tdata[15:0]        | result and flags out
//
// Three register stages: low nibble and decimal adjust decisions, high nibble
// and correction add, then result and flag selection into the output register.
// An accepted beat passes through the stage 1, stage 2 and output registers; one
// beat is accepted every cycle while the output side takes results.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// A stall at the output freezes the full stages, and upstream stages keep
// moving until they reach a full stage.
module cpu_alu_8bit_flags_unit
  import alu83_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: acc[7:0], operand[15:8], zero_in[16], subtract_in[17],
  // half_in[18], carry_in[19], zero fill[23:20]
  input  logic [23:0] s_axis_tdata,
  // tuser: req_type[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: result[7:0], zero_out[8], subtract_out[9], half_out[10],
  // carry_out[11], zero fill[15:12]
  output logic [15:0] m_axis_tdata
);

  logic [2:0]       vld;
  adv_t             adv;
  logic [DataW-1:0] result;
  logic             zero_out;
  logic             subtract_out;
  logic             half_out;
  logic             carry_out;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    adv.ld3 = !vld[2] || m_axis_tready;
    adv.ld2 = !vld[1] || adv.ld3;
    adv.ld1 = !vld[0] || adv.ld2;
  end

  assign s_axis_tready = adv.ld1;
  assign m_axis_tvalid = vld[2];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv.ld1) begin
        vld[0] <= s_axis_tvalid;
      end
      if (adv.ld2) begin
        vld[1] <= vld[0];
      end
      if (adv.ld3) begin
        vld[2] <= vld[1];
      end
    end
  end

  alu83_pipe u_pipe (
    .clk          (clk),
    .adv          (adv),
    .op           (op_t'(s_axis_tuser)),
    .acc          (s_axis_tdata[7:0]),
    .operand      (s_axis_tdata[15:8]),
    .zero_in      (s_axis_tdata[16]),
    .subtract_in  (s_axis_tdata[17]),
    .half_in      (s_axis_tdata[18]),
    .carry_in     (s_axis_tdata[19]),
    .result       (result),
    .zero_out     (zero_out),
    .subtract_out (subtract_out),
    .half_out     (half_out),
    .carry_out    (carry_out)
  );

  assign m_axis_tdata = {4'b0000, carry_out, half_out, subtract_out, zero_out, result};

  // An accepted beat occupies the first stage next cycle.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted beat did not enter stage one");

  // A full pipeline with a stalled output takes nothing.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (vld == 3'b111 && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline full and stalled");

  // Beats in flight change only by accepted inputs and delivered outputs.
  a_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(vld) == $countones($past(vld))
      + $past(s_axis_tvalid && s_axis_tready) - $past(m_axis_tvalid && m_axis_tready)))
    else $error("beat lost or created in pipeline");

  // The output stage fills only from a valid middle stage.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(vld[2])) |-> $past(vld[1]))
    else $error("output valid without a beat behind it");

endmodule

[sim/tb_top.sv]
module tb_top;
  import alu83_pkg::*;

  // Result beat as it leaves the block: value in the low byte, flags above it.
  typedef struct packed {
    logic       cf;
    logic       hf;
    logic       nf;
    logic       zf;
    logic [7:0] value;
  } alu_out_t;

  // One line of the directed stimulus table; flags are packed {c, h, n, z}.
  typedef struct packed {
    op_t        op;
    logic [7:0] acc;
    logic [7:0] opnd;
    logic [3:0] fin;
    logic       known;
    alu_out_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // Expectation that travels with the beat being offered (directed rows only).
  logic        beat_known = 1'b0;
  alu_out_t    beat_want = '0;

  alu_out_t    alu_results_due[$];
  dir_row_t    directed_rows[$];
  int          fail_count = 0;
  int          results_checked = 0;
  int          beats_sent = 0;
  bit          calm_phase = 1'b0;

  cpu_alu_8bit_flags_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Computes the SM83 result and flags for one operation.
  function automatic alu_out_t sm83_alu_eval(op_t op, logic [7:0] a, logic [7:0] b,
                                             logic [3:0] fin);
    alu_out_t   r;
    logic [8:0] wide;
    logic [4:0] nib;
    logic       cin;
    logic [7:0] res;
    logic       zf, nf, hf, cf;
    logic       zero_from_res;
    zf = fin[0];
    nf = fin[1];
    hf = fin[2];
    cf = fin[3];
    res = a;
    zero_from_res = 1'b1;
    case (op)
      OP_ADD, OP_ADC: begin
        cin = (op == OP_ADC) ? fin[3] : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + cin;
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + cin;
        res = wide[7:0];
        hf = nib[4];
        cf = wide[8];
        nf = 1'b0;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // Bit 8 and bit 4 of the differences are the borrows.
        cin = (op == OP_SBC) ? fin[3] : 1'b0;
        wide = {1'b0, a} - {1'b0, b} - cin;
        nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - cin;
        hf = nib[4];
        cf = wide[8];
        nf = 1'b1;
        if (op == OP_CP) begin
          zf = (wide[7:0] == 8'h00);
          zero_from_res = 1'b0;
        end else begin
          res = wide[7:0];
        end
      end
      OP_AND: begin
        res = a & b;
        nf = 1'b0;
        hf = 1'b1;
        cf = 1'b0;
      end
      OP_XOR: begin
        res = a ^ b;
        nf = 1'b0;
        hf = 1'b0;
        cf = 1'b0;
      end
      OP_OR: begin
        res = a | b;
        nf = 1'b0;
        hf = 1'b0;
        cf = 1'b0;
      end
      OP_INC: begin
        res = b + 8'h01;
        nf = 1'b0;
        hf = (res[3:0] == 4'h0);
      end
      OP_DEC: begin
        res = b - 8'h01;
        nf = 1'b1;
        hf = (res[3:0] == 4'hf);
      end
      OP_DAA: begin
        // Both decisions look at the accumulator before any correction.
        if (!fin[1]) begin
          if (fin[3] || a > 8'h99) begin
            res = res + 8'h60;
            cf = 1'b1;
          end
          if (fin[2] || a[3:0] > 4'd9) begin
            res = res + 8'h06;
          end
        end else begin
          if (fin[3]) begin
            res = res - 8'h60;
          end
          if (fin[2]) begin
            res = res - 8'h06;
          end
        end
        hf = 1'b0;
      end
      OP_CPL: begin
        res = ~a;
        nf = 1'b1;
        hf = 1'b1;
        zero_from_res = 1'b0;
      end
      OP_SCF: begin
        nf = 1'b0;
        hf = 1'b0;
        cf = 1'b1;
        zero_from_res = 1'b0;
      end
      OP_CCF: begin
        nf = 1'b0;
        hf = 1'b0;
        cf = ~fin[3];
        zero_from_res = 1'b0;
      end
      OP_SRL: begin
        res = {1'b0, b[7:1]};
        cf = b[0];
        nf = 1'b0;
        hf = 1'b0;
      end
      default: begin
        // Rotate right through carry.
        res = {fin[3], b[7:1]};
        cf = b[0];
        nf = 1'b0;
        hf = 1'b0;
      end
    endcase
    if (zero_from_res) begin
      zf = (res == 8'h00);
    end
    r.value = res;
    r.zf = zf;
    r.nf = nf;
    r.hf = hf;
    r.cf = cf;
    return r;
  endfunction

  function automatic int draw_wait();
    return calm_phase ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR: %s", msg);
    end
  endtask

  task automatic check_result(input alu_out_t want, input alu_out_t got);
    if (got.value !== want.value) begin
      report_failure($sformatf("beat %0d result: expected 0x%02h, got 0x%02h",
                               results_checked, want.value, got.value));
    end
    if (got.zf !== want.zf) begin
      report_failure($sformatf("beat %0d zero flag: expected %b, got %b",
                               results_checked, want.zf, got.zf));
    end
    if (got.nf !== want.nf) begin
      report_failure($sformatf("beat %0d subtract flag: expected %b, got %b",
                               results_checked, want.nf, got.nf));
    end
    if (got.hf !== want.hf) begin
      report_failure($sformatf("beat %0d half carry flag: expected %b, got %b",
                               results_checked, want.hf, got.hf));
    end
    if (got.cf !== want.cf) begin
      report_failure($sformatf("beat %0d carry flag: expected %b, got %b",
                               results_checked, want.cf, got.cf));
    end
  endtask

  task automatic add_row(input op_t op, input logic [7:0] acc, input logic [7:0] opnd,
                         input logic [3:0] fin, input logic known,
                         input logic [3:0] wflags, input logic [7:0] wval);
    dir_row_t row;
    row.op = op;
    row.acc = acc;
    row.opnd = opnd;
    row.fin = fin;
    row.known = known;
    row.want = {wflags, wval};
    directed_rows.push_back(row);
  endtask

  // Offers one beat after a random gap and returns at the edge that takes it.
  task automatic push_beat(input op_t op, input logic [7:0] acc, input logic [7:0] opnd,
                           input logic [3:0] fin, input logic known, input alu_out_t want);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0000, fin, opnd, acc};
    beat_known <= known;
    beat_want <= want;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Scoreboard: queue the expectation of each accepted input beat, then check
  // the output beat of the same edge against the oldest one.
  always @(posedge clk) begin : scoreboard
    alu_out_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (beat_known) begin
          alu_results_due.push_back(beat_want);
        end else begin
          alu_results_due.push_back(sm83_alu_eval(op_t'(s_axis_tuser), s_axis_tdata[7:0],
                                                  s_axis_tdata[15:8], s_axis_tdata[19:16]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[11:0];
        if (alu_results_due.size() == 0) begin
          report_failure($sformatf("result beat 0x%03h with nothing outstanding",
                                   m_axis_tdata[11:0]));
        end else begin
          check_result(alu_results_due.pop_front(), got);
        end
        results_checked++;
      end
    end
  end

  // Output side: a random stall before each result beat is taken.
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    dir_row_t   row;
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
    logic [3:0] fin;
    int         n_rand;

    // Directed table. Flags are written {c, h, n, z}; rows marked 1 carry
    // their expected flags and value, the rest go through the predictor.
    add_row(OP_ADD, 8'hff, 8'h01, 4'b0000, 1'b1, 4'b1101, 8'h00);
    add_row(OP_ADD, 8'h08, 8'h08, 4'b0000, 1'b0, 4'b0000, 8'h00);
    add_row(OP_ADC, 8'hff, 8'hff, 4'b1000, 1'b1, 4'b1100, 8'hff);
    add_row(OP_ADC, 8'h0f, 8'h00, 4'b1000, 1'b0, 4'b0000, 8'h00);
    add_row(OP_SUB, 8'h00, 8'h01, 4'b0000, 1'b1, 4'b1110, 8'hff);
    add_row(OP_SUB, 8'h10, 8'h01, 4'b0000, 1'b0, 4'b0000, 8'h00);
    add_row(OP_SBC, 8'h10, 8'h0f, 4'b1000, 1'b1, 4'b0111, 8'h00);
    add_row(OP_SBC, 8'h00, 8'hff, 4'b1000, 1'b0, 4'b0000, 8'h00);
    add_row(OP_AND, 8'hff, 8'h00, 4'b0000, 1'b1, 4'b0101, 8'h00);
    add_row(OP_XOR, 8'haa, 8'haa, 4'b1111, 1'b1, 4'b0001, 8'h00);
    add_row(OP_OR,  8'h0f, 8'hf0, 4'b0001, 1'b1, 4'b0000, 8'hff);
    add_row(OP_CP,  8'h42, 8'h42, 4'b0000, 1'b1, 4'b0011, 8'h42);
    add_row(OP_CP,  8'h10, 8'h20, 4'b0000, 1'b0, 4'b0000, 8'h00);
    add_row(OP_INC, 8'h00, 8'hff, 4'b1000, 1'b1, 4'b1101, 8'h00);
    add_row(OP_INC, 8'h00, 8'h0f, 4'b0000, 1'b0, 4'b0000, 8'h00);
    add_row(OP_DEC, 8'h00, 8'h00, 4'b0000, 1'b1, 4'b0110, 8'hff);
    // Decimal adjust: both corrections after an add, both after a subtract,
    // and the low nibble alone in either direction.
    add_row(OP_DAA, 8'h9a, 8'h00, 4'b0000, 1'b1, 4'b1001, 8'h00);
    add_row(OP_DAA, 8'h00, 8'h00, 4'b1110, 1'b1, 4'b1010, 8'h9a);
    add_row(OP_DAA, 8'h45, 8'h00, 4'b0100, 1'b0, 4'b0000, 8'h00);
    add_row(OP_DAA, 8'h36, 8'h00, 4'b0110, 1'b0, 4'b0000, 8'h00);
    add_row(OP_CPL, 8'h00, 8'h00, 4'b1001, 1'b1, 4'b1111, 8'hff);
    add_row(OP_SCF, 8'h55, 8'h00, 4'b0110, 1'b1, 4'b1000, 8'h55);
    add_row(OP_CCF, 8'h00, 8'h00, 4'b1001, 1'b1, 4'b0001, 8'h00);
    add_row(OP_SRL, 8'h00, 8'h01, 4'b0000, 1'b1, 4'b1001, 8'h00);
    add_row(OP_SRL, 8'h00, 8'hfe, 4'b1111, 1'b0, 4'b0000, 8'h00);
    add_row(OP_RR,  8'h00, 8'h01, 4'b1000, 1'b1, 4'b1000, 8'h80);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      push_beat(row.op, row.acc, row.opnd, row.fin, row.known, row.want);
    end

    // Random part; every third stretch of 150 beats runs with no idling.
    n_rand = 1800;
    for (int n = 0; n < n_rand; n++) begin
      calm_phase = ((n / 150) % 3 == 2);
      if (n == n_rand / 2) begin
        // Let the pipeline drain completely before going on.
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (alu_results_due.size() != 0) @(posedge clk);
      end
      op = op_t'($urandom_range(0, 15));
      a = 8'($urandom);
      fin = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
        0: b = a;
        1: begin
          case ($urandom_range(0, 5))
            0: b = 8'h00;
            1: b = 8'hff;
            2: b = 8'h0f;
            3: b = 8'h10;
            4: b = 8'h99;
            default: b = 8'h01;
          endcase
        end
        default: b = 8'($urandom);
      endcase
      push_beat(op, a, b, fin, 1'b0, '0);
    end
    calm_phase = 1'b0;
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (alu_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d beats (%0d directed, %0d random) over all 16 operations,",
             beats_sent, directed_rows.size(), n_rand);
    $display("with random gaps and stalls on both sides; %0d result beats were checked.",
             results_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
